/* design/lbpg_pkg.sv */
// Shared types, constants and helper functions for the LED blink pattern generator.
package lbpg_pkg;

    localparam int SEQUENCE_SLOTS = 8;
    localparam int COLOR_COUNT    = 4;
    localparam int MAX_ZONE_LEDS  = 1024;
    localparam int FQ_DEPTH       = 2;

    // turns per Q16.16 time unit, scaled by 2^40
    localparam logic [21:0] TURN_SCALE = 22'd2670177;
    localparam logic signed [35:0] ONE_Q16 = 36'sd65536;

    // pattern numbers
    localparam logic [4:0] PAT_BLINK_A   = 5'd0;
    localparam logic [4:0] PAT_BLINK_B   = 5'd1;
    localparam logic [4:0] PAT_MARQ_A    = 5'd2;
    localparam logic [4:0] PAT_MARQ_B    = 5'd3;
    localparam logic [4:0] PAT_MARQ_C    = 5'd4;
    localparam logic [4:0] PAT_MARQ_D    = 5'd5;
    localparam logic [4:0] PAT_BREATH_A  = 5'd6;
    localparam logic [4:0] PAT_BREATH_B  = 5'd7;
    localparam logic [4:0] PAT_BREATH_C  = 5'd8;
    localparam logic [4:0] PAT_BREATH_D  = 5'd9;
    localparam logic [4:0] PAT_BREATH_E  = 5'd10;
    localparam logic [4:0] PAT_BAND_A    = 5'd11;
    localparam logic [4:0] PAT_BAND_B    = 5'd12;
    localparam logic [4:0] PAT_BAND_C    = 5'd13;
    localparam logic [4:0] PAT_BAND_D    = 5'd14;
    localparam logic [4:0] PAT_FLASH_2   = 5'd15;
    localparam logic [4:0] PAT_FLASH_4   = 5'd16;
    localparam logic [4:0] PAT_FLASH_8   = 5'd17;
    localparam logic [4:0] PAT_FLASH_16  = 5'd18;
    localparam logic [4:0] PAT_ALT_A     = 5'd19;
    localparam logic [4:0] PAT_ALT_B     = 5'd20;

    // time offset modes
    localparam logic [2:0] OFS_NONE  = 3'd0;
    localparam logic [2:0] OFS_PLUS  = 3'd1;
    localparam logic [2:0] OFS_MINUS = 3'd2;
    localparam logic [2:0] OFS_PLUS2 = 3'd3;
    localparam logic [2:0] OFS_MIN2  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_COLOR0   = 3'd0;
    localparam logic [2:0] REG_COLOR1   = 3'd1;
    localparam logic [2:0] REG_COLOR2   = 3'd2;
    localparam logic [2:0] REG_COLOR3   = 3'd3;
    localparam logic [2:0] REG_INTERVAL = 3'd4;
    localparam logic [2:0] REG_TSTEP    = 3'd5;
    localparam logic [2:0] REG_SEQ      = 3'd6;
    localparam logic [2:0] REG_SEQLEN   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_PUSH
    } front_state_t;

    typedef struct packed {
        logic [COLOR_COUNT-1:0][23:0] color;
        logic [15:0]                  step_interval;
        logic [15:0]                  time_step;
        logic [39:0]                  pattern_sequence;
        logic [3:0]                   sequence_length;
    } cfg_t;

    typedef struct packed {
        logic        is_tick;
        logic        active;
        logic [2:0]  slot;
        logic [4:0]  pat;
        logic [9:0]  x;
        logic [10:0] w;
        logic [31:0] tm;
    } entry_t;

    function automatic logic [7:0] qwave(input logic [6:0] i);
        logic [7:0] r;
        case (i)
            7'd0: r = 8'd0;     7'd1: r = 8'd3;     7'd2: r = 8'd6;     7'd3: r = 8'd9;
            7'd4: r = 8'd13;    7'd5: r = 8'd16;    7'd6: r = 8'd19;    7'd7: r = 8'd22;
            7'd8: r = 8'd25;    7'd9: r = 8'd28;    7'd10: r = 8'd31;   7'd11: r = 8'd34;
            7'd12: r = 8'd37;   7'd13: r = 8'd40;   7'd14: r = 8'd43;   7'd15: r = 8'd46;
            7'd16: r = 8'd49;   7'd17: r = 8'd52;   7'd18: r = 8'd55;   7'd19: r = 8'd58;
            7'd20: r = 8'd60;   7'd21: r = 8'd63;   7'd22: r = 8'd66;   7'd23: r = 8'd68;
            7'd24: r = 8'd71;   7'd25: r = 8'd74;   7'd26: r = 8'd76;   7'd27: r = 8'd79;
            7'd28: r = 8'd81;   7'd29: r = 8'd84;   7'd30: r = 8'd86;   7'd31: r = 8'd88;
            7'd32: r = 8'd91;   7'd33: r = 8'd93;   7'd34: r = 8'd95;   7'd35: r = 8'd97;
            7'd36: r = 8'd99;   7'd37: r = 8'd101;  7'd38: r = 8'd103;  7'd39: r = 8'd105;
            7'd40: r = 8'd106;  7'd41: r = 8'd108;  7'd42: r = 8'd110;  7'd43: r = 8'd111;
            7'd44: r = 8'd113;  7'd45: r = 8'd114;  7'd46: r = 8'd116;  7'd47: r = 8'd117;
            7'd48: r = 8'd118;  7'd49: r = 8'd119;  7'd50: r = 8'd121;  7'd51: r = 8'd122;
            7'd52: r = 8'd122;  7'd53: r = 8'd123;  7'd54: r = 8'd124;  7'd55: r = 8'd125;
            7'd56: r = 8'd126;  7'd57: r = 8'd126;  7'd58: r = 8'd127;  7'd59: r = 8'd127;
            7'd60: r = 8'd127;  7'd61: r = 8'd128;  7'd62: r = 8'd128;  7'd63: r = 8'd128;
            7'd64: r = 8'd128;
            default: r = 8'd0;
        endcase
        return r;
    endfunction

    // Q0.8 sine brightness from an 8-bit phase
    function automatic logic [7:0] sine_level(input logic [7:0] p);
        logic [7:0] m;
        logic [8:0] b;
        m = p[6] ? qwave(7'd64 - {1'b0, p[5:0]}) : qwave({1'b0, p[5:0]});
        b = p[7] ? (9'd128 - {1'b0, m}) : (9'd128 + {1'b0, m});
        return b[8] ? 8'd255 : b[7:0];
    endfunction

    // floor(ch * b / 255) for one channel
    function automatic logic [7:0] scale_ch(input logic [7:0] ch, input logic [7:0] b);
        logic [16:0] p;
        logic [16:0] q;
        p = 17'(ch) * 17'(b);
        q = p + {8'd0, p[16:8]} + 17'd1;
        return q[15:8];
    endfunction

    function automatic logic [23:0] dim(input logic [23:0] c, input logic [7:0] b);
        return {scale_ch(c[23:16], b), scale_ch(c[15:8], b), scale_ch(c[7:0], b)};
    endfunction

    // |trunc(v / 2^16)|
    function automatic logic [19:0] abs_whole(input logic signed [35:0] v);
        logic [35:0] mag;
        mag = v[35] ? 36'(-v) : 36'(v);
        return mag[35:16];
    endfunction

endpackage

/* design/led_blink_pattern_generator_top.sv */
// Top level of the LED blink pattern generator: config registers and stream channels.
//
// Usage:
//   s_ channel: one request per handshake. s_tuser[0] = 1 is a time tick, 0 a pixel
//   query; s_tdata carries the LED position and zone width. m_ channel returns one
//   result per request, in order: 24-bit color, slot in force and an active flag.
//   Config: write cfg_wdata into register cfg_addr while cfg_we is high; only while
//   the block is idle.
// Flow: the front end takes no new request until the last one is queued (accept, a
//   bit-serial divide of the whole time by the step interval, then a push to the queue).
// Path from accept to m_tvalid: the front end, the queue, then the two back-end stages:
//   sine phase multiply, then color select into the output register.
// Reset (aresetn low, synchronous): time cleared, colors and sequence zeroed,
//   step_interval 1, time_step 1092; queue and output emptied.
// Stall: when m_tready is low the result holds in the output register; the back end
//   and the queue fill behind it, then the front end stops taking requests.
module led_blink_pattern_generator_top #(
    parameter int QUEUE_DEPTH = lbpg_pkg::FQ_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // led_pos[9:0], zone_width[20:10], zero pad
    input  logic [0:0]  s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // color[23:0], step_index[26:24], zero pad
    output logic [0:0]  m_tuser,   // active[0]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [39:0] cfg_wdata
);
    import lbpg_pkg::*;

    cfg_t   cfg_reg;
    logic   push, q_full, pop, q_empty;
    entry_t push_entry, q_data;
    logic [23:0] color;
    logic        active;
    logic [2:0]  step;

    // config write port; no read back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color            <= '0;
            cfg_reg.step_interval    <= 16'd1;
            cfg_reg.time_step        <= 16'd1092;
            cfg_reg.pattern_sequence <= 40'd0;
            cfg_reg.sequence_length  <= 4'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_COLOR0:   cfg_reg.color[0]         <= cfg_wdata[23:0];
                REG_COLOR1:   cfg_reg.color[1]         <= cfg_wdata[23:0];
                REG_COLOR2:   cfg_reg.color[2]         <= cfg_wdata[23:0];
                REG_COLOR3:   cfg_reg.color[3]         <= cfg_wdata[23:0];
                REG_INTERVAL: cfg_reg.step_interval    <= cfg_wdata[15:0];
                REG_TSTEP:    cfg_reg.time_step        <= cfg_wdata[15:0];
                REG_SEQ:      cfg_reg.pattern_sequence <= cfg_wdata;
                REG_SEQLEN:   cfg_reg.sequence_length  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // front end: time accumulator and slot divider
    lbpg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_tick    (s_tuser[0]),
        .in_x       (s_tdata[9:0]),
        .in_w       (s_tdata[20:10]),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    lbpg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (push),
        .wr_data (push_entry),
        .full    (q_full),
        .rd_en   (pop),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // back end: pattern color and output register
    lbpg_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .q_data     (q_data),
        .q_empty    (q_empty),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_color  (color),
        .out_active (active),
        .out_step   (step)
    );

    assign m_tdata = {5'd0, step, color};
    assign m_tuser = active;

endmodule

/* design/lbpg_front.sv */
// Front end: accepts requests, advances time on ticks, finds the sequence slot.
module lbpg_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lbpg_pkg::cfg_t       cfg,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 in_tick,
    input  logic [9:0]           in_x,
    input  logic [10:0]          in_w,
    output logic                 push,
    output lbpg_pkg::entry_t     push_entry,
    input  logic                 q_full
);
    import lbpg_pkg::*;

    front_state_t state_reg, state_next;
    logic [31:0] time_reg;
    logic        tick_reg;
    logic [9:0]  x_reg;
    logic [10:0] w_reg;
    logic [16:0] rem_reg;
    logic [3:0]  slot_rem_reg;
    logic [3:0]  bit_cnt_reg;

    logic        accept;
    logic [3:0]  len;
    logic [15:0] iv;
    logic [15:0] num;
    logic [16:0] shifted;
    logic        q_bit;
    logic [16:0] rem_step;
    logic [3:0]  r2;
    logic [3:0]  slot_step;

    assign len = (cfg.sequence_length > 4'(SEQUENCE_SLOTS)) ? 4'(SEQUENCE_SLOTS)
                                                           : cfg.sequence_length;
    assign iv  = (cfg.step_interval == 16'd0) ? 16'd1 : cfg.step_interval;
    assign num = time_reg[31:16];

    // one quotient bit per cycle; slot remainder mod len tracked alongside
    assign shifted   = {rem_reg[15:0], num[bit_cnt_reg]};
    assign q_bit     = shifted >= {1'b0, iv};
    assign rem_step  = q_bit ? (shifted - {1'b0, iv}) : shifted;
    assign r2        = {slot_rem_reg[2:0], q_bit};
    assign slot_step = (len != 4'd0 && r2 >= len) ? (r2 - len) : r2;

    assign accept = in_valid && in_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_DIV;
            ST_DIV:  if (bit_cnt_reg == 4'd0) state_next = ST_PUSH;
            ST_PUSH: if (!q_full) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        push     = 1'b0;
        case (state_reg)
            ST_IDLE: in_ready = 1'b1;
            ST_DIV:  ;
            ST_PUSH: push = !q_full;
            default: ;
        endcase
    end

    always_comb begin
        push_entry.is_tick = tick_reg;
        push_entry.active  = len != 4'd0;
        push_entry.slot    = (len == 4'd0) ? 3'd0 : slot_rem_reg[2:0];
        push_entry.pat     = cfg.pattern_sequence[int'(slot_rem_reg[2:0]) * 5 +: 5];
        push_entry.x       = x_reg;
        push_entry.w       = w_reg;
        push_entry.tm      = time_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            time_reg  <= 32'd0;
        end else begin
            state_reg <= state_next;
            if (accept && in_tick)
                time_reg <= time_reg + {16'd0, cfg.time_step};
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tick_reg     <= in_tick;
            x_reg        <= in_x;
            w_reg        <= in_w;
            rem_reg      <= 17'd0;
            slot_rem_reg <= 4'd0;
            bit_cnt_reg  <= 4'd15;
        end else if (state_reg == ST_DIV) begin
            rem_reg      <= rem_step;
            slot_rem_reg <= slot_step;
            bit_cnt_reg  <= bit_cnt_reg - 4'd1;
        end
    end

    a_accept_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_DIV)
        else $error("front did not start divide after accept");

    a_slot_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        push && push_entry.active |-> {1'b0, push_entry.slot} < len)
        else $error("slot outside sequence length");

endmodule

/* design/lbpg_queue.sv */
// Short FIFO between the front end and the color back end.
module lbpg_queue #(
    parameter int DEPTH = lbpg_pkg::FQ_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  lbpg_pkg::entry_t  wr_data,
    output logic              full,
    input  logic              rd_en,
    output lbpg_pkg::entry_t  rd_data,
    output logic              empty
);
    import lbpg_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == CW'(0);
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            if (wr_en && !rd_en)
                count_reg <= count_reg + CW'(1);
            else if (rd_en && !wr_en)
                count_reg <= count_reg - CW'(1);
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> !full)
        else $error("queue write while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> !empty)
        else $error("queue read while empty");

endmodule

/* design/lbpg_back.sv */
// Back end: sine phase multiply, pattern color selection and output register.
module lbpg_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  lbpg_pkg::cfg_t    cfg,
    input  lbpg_pkg::entry_t  q_data,
    input  logic              q_empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [23:0]       out_color,
    output logic              out_active,
    output logic [2:0]        out_step
);
    import lbpg_pkg::*;

    logic        s1_valid_reg;
    entry_t      s1_reg;
    logic [53:0] prod_reg;
    logic        o_valid_reg;
    logic [23:0] o_color_reg;
    logic        o_active_reg;
    logic [2:0]  o_step_reg;

    logic        advance;
    logic        s1_take;
    logic        even;
    logic [10:0] w_sat;
    logic [2:0]  mode;
    logic [1:0]  bank;
    logic signed [35:0] base, tq, v;
    logic [19:0] a0, a1;
    logic [7:0]  lvl1, lvl2, lvlf;
    logic [2:0]  fk;
    logic [23:0] base_color;
    logic [7:0]  bright;
    logic        use_dim;
    logic [23:0] pix;

    assign advance = !o_valid_reg || out_ready;
    assign s1_take = !s1_valid_reg || advance;
    assign pop     = s1_take && !q_empty;

    assign even  = !s1_reg.tm[16];
    assign w_sat = (s1_reg.w > 11'(MAX_ZONE_LEDS)) ? 11'(MAX_ZONE_LEDS) : s1_reg.w;

    always_comb begin
        mode = OFS_NONE;
        case (s1_reg.pat)
            PAT_MARQ_A, PAT_BREATH_B, PAT_BAND_A:   mode = OFS_PLUS;
            PAT_MARQ_B, PAT_BREATH_D, PAT_BAND_B:   mode = OFS_MINUS;
            PAT_MARQ_C, PAT_BAND_C:                 mode = OFS_PLUS2;
            PAT_MARQ_D, PAT_BAND_D:                 mode = OFS_MIN2;
            default:                                mode = OFS_NONE;
        endcase
    end

    assign base = $signed({10'd0, s1_reg.x, 16'd0});
    assign tq   = $signed({4'd0, s1_reg.tm});

    always_comb begin
        case (mode)
            OFS_PLUS:  v = base + tq;
            OFS_MINUS: v = base - tq;
            OFS_PLUS2: v = base + (tq <<< 1);
            OFS_MIN2:  v = base - (tq <<< 1);
            default:   v = base;
        endcase
    end

    assign a0 = abs_whole(v);
    assign a1 = abs_whole(v + ONE_Q16);

    // phase of sine(mult = 2^k) is bits [39-k:32-k] of time * TURN_SCALE;
    // flash patterns use mult 2, 4, 8, 16, so k = pat - 14
    assign fk   = 3'(s1_reg.pat - PAT_BAND_D);
    assign lvl1 = sine_level(prod_reg[39:32]);
    assign lvl2 = sine_level(prod_reg[38:31]);
    assign lvlf = sine_level(prod_reg[6'd39 - 6'(fk) -: 8]);

    always_comb begin
        base_color = 24'd0;
        bright     = 8'd255;
        use_dim    = 1'b0;
        bank       = 2'd0;
        case (s1_reg.pat)
            PAT_BLINK_A, PAT_BLINK_B, PAT_MARQ_A, PAT_MARQ_B, PAT_MARQ_C, PAT_MARQ_D: begin
                bank = s1_reg.pat[0] ? 2'd2 : 2'd0;
                if (!a0[0])
                    base_color = 24'd0;
                else if (a1[1:0] == 2'd0)
                    base_color = cfg.color[even ? bank : bank + 2'd1];
                else
                    base_color = cfg.color[even ? bank + 2'd1 : bank];
            end
            PAT_BREATH_A, PAT_BREATH_B, PAT_BREATH_C, PAT_BREATH_D: begin
                bank = s1_reg.pat[1] ? 2'd0 : 2'd2;
                if (a0[0]) begin
                    use_dim = 1'b1;
                    if (a1[1:0] == 2'd0) begin
                        base_color = cfg.color[bank];
                        bright     = lvl1;
                    end else begin
                        base_color = cfg.color[bank + 2'd1];
                        bright     = lvl2;
                    end
                end
            end
            PAT_BREATH_E: begin
                use_dim    = 1'b1;
                base_color = cfg.color[s1_reg.x[1:0]];
                bright     = s1_reg.x[0] ? 8'd255 - lvl1 : lvl1;
            end
            PAT_BAND_A, PAT_BAND_B, PAT_BAND_C, PAT_BAND_D:
                base_color = cfg.color[a0[1:0]];
            PAT_FLASH_2, PAT_FLASH_4, PAT_FLASH_8, PAT_FLASH_16:
                base_color = (lvlf > 8'd128) ? cfg.color[s1_reg.x[1:0]] : 24'd0;
            PAT_ALT_A:
                base_color = ({s1_reg.x, 1'b0} >= w_sat) ? cfg.color[even ? 2'd0 : 2'd1]
                                                         : cfg.color[even ? 2'd1 : 2'd0];
            PAT_ALT_B:
                base_color = ({s1_reg.x, 1'b0} >= w_sat) ? cfg.color[even ? 2'd2 : 2'd3]
                                                         : cfg.color[even ? 2'd3 : 2'd2];
            default: base_color = 24'd0;
        endcase
    end

    assign pix = (s1_reg.is_tick || !s1_reg.active) ? 24'd0
               : (use_dim ? dim(base_color, bright) : base_color);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end else begin
            if (s1_take)
                s1_valid_reg <= !q_empty;
            if (advance)
                o_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            s1_reg   <= q_data;
            prod_reg <= q_data.tm * TURN_SCALE;
        end
        if (advance && s1_valid_reg) begin
            o_color_reg  <= pix;
            o_active_reg <= s1_reg.active;
            o_step_reg   <= s1_reg.slot;
        end
    end

    assign out_valid  = o_valid_reg;
    assign out_color  = o_color_reg;
    assign out_active = o_active_reg;
    assign out_step   = o_step_reg;

    a_inactive_dark: assert property (@(posedge aclk) disable iff (!aresetn)
        o_valid_reg && !o_active_reg |-> o_color_reg == 24'd0 && o_step_reg == 3'd0)
        else $error("inactive result carries color or slot");

endmodule
